>>> rtl/rq_pkg.sv
`timescale 1ns / 1ps
package rq_pkg;
    localparam int LANES = 4;
    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_ZERO  = 2'd1;
    localparam logic [1:0] REG_CLO   = 2'd2;
    localparam logic [1:0] REG_CHI   = 2'd3;

    typedef struct packed {
        logic [29:0] scale_bits;
        logic [7:0]  zero_offset;
        logic [7:0]  clamp_low;
        logic [7:0]  clamp_high;
    } cfg_t;

    // stage 1 -> stage 2 lane state: rounded value, sign
    typedef struct packed {
        logic        neg;
        logic [23:0] m;     // 24-bit significand of converted accumulator
        logic [5:0]  e;     // its exponent (0..9)
    } conv_t;

    function automatic logic [5:0] top_bit48(input logic [47:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 48; i++)
            if (v[i]) p = 6'(i);
        return p;
    endfunction
endpackage

>>> rtl/rq_lane.sv
`timescale 1ns / 1ps
// One requantization lane: four register stages (convert, multiply, round to single,
// round to integer and clamp).
module rq_lane (
    input  logic                 clk,
    input  logic                 en,
    input  rq_pkg::cfg_t         cfg,
    input  logic [31:0]          acc,
    output logic [7:0]           byte_q
);
    import rq_pkg::*;

    // stage 1: int32 -> single
    logic        neg;
    logic [31:0] mag;
    logic [5:0]  p1;
    logic [5:0]  sh1;
    logic [31:0] q1, rem1, half1;
    logic [24:0] r1;
    conv_t       c_next, c_reg;

    always_comb
    begin
        neg = acc[31];
        mag = neg ? (~acc + 32'd1) : acc;
        p1 = top_bit48({16'd0, mag});
        c_next.neg = neg;
        c_next.m = mag[23:0];
        c_next.e = '0;
        q1 = '0; rem1 = '0; half1 = '0; r1 = '0; sh1 = '0;
        if (p1 > 6'd23)
        begin
            sh1 = p1 - 6'd23;
            q1 = mag >> sh1;
            rem1 = mag & ((32'd1 << sh1) - 32'd1);
            half1 = 32'd1 << (sh1 - 6'd1);
            r1 = q1[24:0];
            if (rem1 > half1 || (rem1 == half1 && q1[0])) r1 = r1 + 25'd1;
            if (r1[24])
            begin
                c_next.m = r1[24:1];
                c_next.e = sh1 + 6'd1;
            end
            else
            begin
                c_next.m = r1[23:0];
                c_next.e = sh1;
            end
        end
    end

    // stage 2: multiply significands
    logic [23:0] sm;
    logic signed [9:0] se;
    logic [47:0] prod_next, prod_reg;
    logic signed [9:0] pe_next, pe_reg;
    logic neg2_reg;

    always_comb
    begin
        sm = {(cfg.scale_bits[29:23] != 7'd0), cfg.scale_bits[22:0]};
        se = (cfg.scale_bits[29:23] == 7'd0) ? -10'sd149
            : $signed({3'd0, cfg.scale_bits[29:23]}) - 10'sd150;
        prod_next = c_reg.m * sm;
        pe_next = $signed({4'd0, c_reg.e}) + se;
    end

    // stage 3: round product to single
    logic [5:0]  p3, sh3;
    logic [47:0] q3, rem3, half3;
    logic [24:0] qm;
    logic signed [10:0] pe;
    logic [23:0] qm_reg;
    logic signed [10:0] pe3_reg;
    logic zero3_reg;
    logic neg3_reg;

    always_comb
    begin
        p3 = top_bit48(prod_reg);
        pe = 11'(pe_reg);
        qm = prod_reg[24:0];
        sh3 = '0; q3 = '0; rem3 = '0; half3 = '0;
        if (p3 > 6'd23)
        begin
            sh3 = p3 - 6'd23;
            q3 = prod_reg >> sh3;
            rem3 = prod_reg & ((48'd1 << sh3) - 48'd1);
            half3 = 48'd1 << (sh3 - 6'd1);
            qm = q3[24:0];
            if (rem3 > half3 || (rem3 == half3 && q3[0])) qm = qm + 25'd1;
            pe = pe + 11'(sh3);
            if (qm[24])
            begin
                qm = {1'b0, qm[24:1]};
                pe = pe + 11'sd1;
            end
        end
    end

    // stage 4: round to integer, saturate, add zero offset, clamp
    logic [10:0] nsh;
    logic [33:0] r;
    logic [33:0] rq, rrem, rhalf;
    logic signed [17:0] v;
    logic [7:0]  b, b_next;

    always_comb
    begin
        nsh = 11'(-pe3_reg);
        rq = '0; rrem = '0; rhalf = '0;
        if (zero3_reg)
            r = '0;
        else if (pe3_reg >= 0)
            r = (pe3_reg > 11'sd9) ? {34{1'b1}} : (34'(qm_reg) << pe3_reg[3:0]);
        else if (pe3_reg < -11'sd33)
            r = '0;     // significand is below half of one unit here
        else
        begin
            rq = 34'(qm_reg) >> nsh[5:0];
            rrem = 34'(qm_reg) & ((34'd1 << nsh[5:0]) - 34'd1);
            rhalf = 34'd1 << (nsh[5:0] - 6'd1);
            r = rq;
            if (rrem > rhalf || (rrem == rhalf && rq[0])) r = r + 34'd1;
        end
        // int16 saturation covers int32 saturation
        if (neg3_reg)
            v = (r > 34'd32768) ? -18'sd32768 : -$signed({1'b0, r[16:0]});
        else
            v = (r > 34'd32767) ? 18'sd32767 : $signed({1'b0, r[16:0]});
        v = v + $signed({10'd0, cfg.zero_offset});
        if (v > 18'sd255) b = 8'd255;
        else if (v < 18'sd0) b = 8'd0;
        else b = v[7:0];
        if (b > cfg.clamp_high) b = cfg.clamp_high;
        if (b < cfg.clamp_low) b = cfg.clamp_low;
        b_next = b;
    end

    logic [7:0] byte_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            prod_reg <= prod_next;
            pe_reg <= pe_next;
            neg2_reg <= c_reg.neg;
            qm_reg <= qm[23:0];
            pe3_reg <= pe;
            zero3_reg <= (prod_reg == 48'd0);
            neg3_reg <= neg2_reg;
            byte_reg <= b_next;
        end
    end
    assign byte_q = byte_reg;
endmodule

>>> rtl/fp32_requantize_int32_to_uint8.sv
`timescale 1ns / 1ps
// Four-lane int32 to uint8 requantizer with a single-precision scale. One word
// per cycle is taken; the whole pipeline stalls when the output word is not
// taken. Each word passes the convert, multiply, round to single, and round to
// integer and clamp stages; the four lanes run in parallel. The user must write
// configuration via the plain write port only while idle (not enforced here).
module fp32_requantize_int32_to_uint8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] acc_0,
    input  logic [31:0] acc_1,
    input  logic [31:0] acc_2,
    input  logic [31:0] acc_3,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_0,
    output logic [7:0]  byte_1,
    output logic [7:0]  byte_2,
    output logic [7:0]  byte_3,
    output logic        last_out
);
    import rq_pkg::*;

    cfg_t cfg_reg;
    logic [3:0] vld_reg;
    logic [3:0] last_reg;
    logic en;

    // advance when the output slot is free or being taken
    assign en = !vld_reg[3] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_bits <= 30'h3F000000;
            cfg_reg.zero_offset <= '0;
            cfg_reg.clamp_low <= '0;
            cfg_reg.clamp_high <= 8'd255;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCALE: cfg_reg.scale_bits <= cfg_data;
                    REG_ZERO:  cfg_reg.zero_offset <= cfg_data[7:0];
                    REG_CLO:   cfg_reg.clamp_low <= cfg_data[7:0];
                    REG_CHI:   cfg_reg.clamp_high <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (en) vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) last_reg <= {last_reg[2:0], last_in};
    end

    logic [31:0] acc [LANES];
    logic [7:0]  bq [LANES];
    assign acc[0] = acc_0;
    assign acc[1] = acc_1;
    assign acc[2] = acc_2;
    assign acc[3] = acc_3;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rq_lane u_lane (.clk(clk), .en(en), .cfg(cfg_reg), .acc(acc[g]), .byte_q(bq[g]));
    end

    assign out_valid = vld_reg[3];
    assign byte_0 = bq[0];
    assign byte_1 = bq[1];
    assign byte_2 = bq[2];
    assign byte_3 = bq[3];
    assign last_out = last_reg[3];
endmodule

>>> rtl/rq_checker.sv
`timescale 1ns / 1ps
module rq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_0,
    input logic       last_out
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_0) && $stable(last_out))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
endmodule

bind fp32_requantize_int32_to_uint8 rq_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .byte_0(byte_0), .last_out(last_out));
